// ===== sv/mcrc_pkg.sv =====
package mcrc_pkg;

    localparam int MAX_COIL_BYTES_DEF = 32;
    localparam int HDR_BYTES = 6;
    localparam int POS_W = 9;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [POS_W-1:0] POS_MAX = 9'd511;

    localparam logic [CFG_IDX_W-1:0] CFG_SLAVE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KIND    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE   = 3'd4;

    localparam logic [1:0] KIND_READ   = 2'd0;
    localparam logic [1:0] KIND_SINGLE = 2'd1;
    localparam logic [1:0] KIND_MULTI  = 2'd2;

    localparam logic [7:0] FUNC_READ   = 8'h01;
    localparam logic [7:0] FUNC_SINGLE = 8'h05;
    localparam logic [7:0] FUNC_MULTI  = 8'h0F;
    localparam logic [7:0] COIL_ON     = 8'hFF;
    localparam logic [7:0] COIL_OFF    = 8'h00;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_LENGTH    = 4'd1;
    localparam logic [3:0] ST_SLAVE     = 4'd2;
    localparam logic [3:0] ST_FUNCTION  = 4'd3;
    localparam logic [3:0] ST_CRC       = 4'd4;
    localparam logic [3:0] ST_BYTECOUNT = 4'd5;
    localparam logic [3:0] ST_ADDRESS   = 4'd6;
    localparam logic [3:0] ST_COUNT     = 4'd7;
    localparam logic [3:0] ST_VALUE     = 4'd8;

    localparam logic ITEM_STATUS = 1'b0;
    localparam logic ITEM_COIL   = 1'b1;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } t_in_word;

    typedef struct packed {
        logic       item_kind;
        logic [3:0] status;
        logic [7:0] coil_byte;
        logic [4:0] coil_index;
        logic       last;
    } t_out_word;

    typedef struct packed {
        logic in_ready;
        logic load_stat;
        logic rd_req;
        logic load_coil;
    } t_ctrl_cmd;

    typedef struct packed {
        logic frame_done;
        logic out_free;
        logic has_coils;
        logic coil_last;
    } t_dp_stat;

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== sv/mcrc_ctrl.sv =====
module mcrc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mcrc_pkg::t_dp_stat   i_stat,
    output mcrc_pkg::t_ctrl_cmd  o_cmd
);
    import mcrc_pkg::*;

    typedef enum logic [3:0] {
        S_RECV  = 4'b0001,
        S_CHECK = 4'b0010,
        S_READ  = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RECV;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_RECV: begin
                o_cmd.in_ready = 1'b1;
                if (i_stat.frame_done) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.load_stat = i_stat.out_free;
                if (i_stat.out_free) begin
                    n_state = i_stat.has_coils ? S_READ : S_RECV;
                end
            end
            S_READ: begin
                o_cmd.rd_req = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.load_coil = i_stat.out_free;
                if (i_stat.out_free) begin
                    n_state = i_stat.coil_last ? S_RECV : S_READ;
                end
            end
            default: begin
                n_state = S_RECV;
            end
        endcase
    end

endmodule

// ===== sv/mcrc_dp.sv =====
module mcrc_dp #(
    parameter int MAX_COIL_BYTES = mcrc_pkg::MAX_COIL_BYTES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mcrc_pkg::t_ctrl_cmd                 i_cmd,
    output mcrc_pkg::t_dp_stat                  o_stat,
    input  logic                                i_in_valid,
    input  mcrc_pkg::t_in_word                  i_in_word,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output mcrc_pkg::t_out_word                 o_out_word,
    input  logic                                i_cfg_we,
    input  logic [mcrc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mcrc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import mcrc_pkg::*;

    localparam int AW = (MAX_COIL_BYTES > 1) ? $clog2(MAX_COIL_BYTES) : 1;
    localparam int CW = $clog2(MAX_COIL_BYTES + 1);

    // configuration
    logic [7:0]  r_exp_slave;
    logic [1:0]  r_exp_kind;
    logic [15:0] r_exp_addr;
    logic [15:0] r_exp_count;
    logic        r_exp_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_slave <= 8'd1;
            r_exp_kind  <= KIND_READ;
            r_exp_addr  <= 16'd0;
            r_exp_count <= 16'd1;
            r_exp_value <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SLAVE:   r_exp_slave <= i_cfg_data[7:0];
                CFG_KIND:    r_exp_kind  <= i_cfg_data[1:0];
                CFG_ADDRESS: r_exp_addr  <= i_cfg_data;
                CFG_COUNT:   r_exp_count <= i_cfg_data;
                CFG_VALUE:   r_exp_value <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // frame state
    logic [POS_W-1:0] r_pos;
    logic [15:0]      r_crc;
    logic [7:0]       r_hdr [HDR_BYTES];
    logic             r_ovf;
    logic [7:0]       r_mem [MAX_COIL_BYTES];
    logic [7:0]       r_rd_data;
    logic [CW-1:0]    r_cnt;
    logic [CW-1:0]    r_idx;
    logic             r_out_valid;
    t_out_word        r_out;

    logic             in_fire;
    logic             out_free;
    logic [POS_W-1:0] pos_off;
    logic             mem_we;

    assign in_fire  = i_in_valid && i_cmd.in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign pos_off  = r_pos - POS_W'(3);
    assign mem_we   = in_fire && !r_ovf && (r_pos >= POS_W'(3))
                      && (pos_off < POS_W'(MAX_COIL_BYTES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load_stat) begin
            r_pos <= '0;
            r_crc <= CRC_INIT;
            r_ovf <= 1'b0;
            for (int h = 0; h < HDR_BYTES; h++) begin
                r_hdr[h] <= 8'h00;
            end
        end else if (in_fire) begin
            r_crc <= crc_update(r_crc, i_in_word.rx_byte);
            if (!r_ovf && r_pos < POS_W'(HDR_BYTES)) begin
                r_hdr[r_pos[2:0]] <= i_in_word.rx_byte;
            end
            if (!i_in_word.frame_end) begin
                if (r_pos >= POS_MAX) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_pos <= r_pos + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[pos_off[AW-1:0]] <= i_in_word.rx_byte;
        end
        if (i_cmd.rd_req) begin
            r_rd_data <= r_mem[r_idx[AW-1:0]];
        end
    end

    // frame checks
    logic [7:0]  bc;
    logic [15:0] hdr_addr;
    logic [15:0] hdr_cnt;
    logic        len_lt5;
    logic        len_8;
    logic        len_bc;
    logic [3:0]  chk_status;
    logic [CW-1:0] chk_cnt;

    assign bc       = r_hdr[2];
    assign hdr_addr = {r_hdr[2], r_hdr[3]};
    assign hdr_cnt  = {r_hdr[4], r_hdr[5]};
    assign len_lt5  = !r_ovf && (r_pos < POS_W'(4));
    assign len_8    = !r_ovf && (r_pos == POS_W'(7));
    assign len_bc   = !r_ovf && ({1'b0, r_pos} == ({2'b00, bc} + 10'd4));

    always_comb begin
        chk_status = ST_OK;
        chk_cnt    = '0;
        case (r_exp_kind)
            KIND_READ: begin
                if (len_lt5) chk_status = ST_LENGTH;
                else if (r_hdr[0] != r_exp_slave) chk_status = ST_SLAVE;
                else if (r_hdr[1] != FUNC_READ) chk_status = ST_FUNCTION;
                else if (r_crc != 16'd0) chk_status = ST_CRC;
                else if (bc == 8'd0 || {5'd0, bc, 3'd0} < r_exp_count)
                    chk_status = ST_BYTECOUNT;
                else if (!len_bc) chk_status = ST_LENGTH;
                else if (bc > 8'(MAX_COIL_BYTES)) chk_status = ST_BYTECOUNT;
                else chk_cnt = CW'(bc);
            end
            KIND_SINGLE: begin
                if (!len_8) chk_status = ST_LENGTH;
                else if (r_hdr[0] != r_exp_slave) chk_status = ST_SLAVE;
                else if (r_hdr[1] != FUNC_SINGLE) chk_status = ST_FUNCTION;
                else if (r_crc != 16'd0) chk_status = ST_CRC;
                else if (hdr_addr != r_exp_addr) chk_status = ST_ADDRESS;
                else if (r_hdr[4] != (r_exp_value ? COIL_ON : COIL_OFF))
                    chk_status = ST_VALUE;
            end
            KIND_MULTI: begin
                if (!len_8) chk_status = ST_LENGTH;
                else if (r_hdr[0] != r_exp_slave) chk_status = ST_SLAVE;
                else if (r_hdr[1] != FUNC_MULTI) chk_status = ST_FUNCTION;
                else if (r_crc != 16'd0) chk_status = ST_CRC;
                else if (hdr_addr != r_exp_addr) chk_status = ST_ADDRESS;
                else if (hdr_cnt != r_exp_count) chk_status = ST_COUNT;
            end
            default: begin
                chk_status = ST_FUNCTION;
            end
        endcase
    end

    // result register
    logic [7:0]    idx_ext;
    logic [CW-1:0] idx_next;

    assign idx_ext  = 8'(r_idx);
    assign idx_next = r_idx + CW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_idx       <= '0;
        end else begin
            if (i_cmd.load_stat || i_cmd.load_coil) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.load_stat) begin
                r_cnt <= chk_cnt;
                r_idx <= '0;
            end else if (i_cmd.load_coil) begin
                r_idx <= idx_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_stat) begin
            r_out.item_kind  <= ITEM_STATUS;
            r_out.status     <= chk_status;
            r_out.coil_byte  <= 8'h00;
            r_out.coil_index <= 5'd0;
            r_out.last       <= (chk_cnt == '0);
        end else if (i_cmd.load_coil) begin
            r_out.item_kind  <= ITEM_COIL;
            r_out.status     <= ST_OK;
            r_out.coil_byte  <= r_rd_data;
            r_out.coil_index <= idx_ext[4:0];
            r_out.last       <= (idx_next == r_cnt);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    assign o_stat.frame_done = in_fire && i_in_word.frame_end;
    assign o_stat.out_free   = out_free;
    assign o_stat.has_coils  = (chk_cnt != '0);
    assign o_stat.coil_last  = (idx_next == r_cnt);

    a_ovf_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_pos == POS_MAX))
        else $error("overflow set below last position");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= r_cnt)
        else $error("coil index past coil count");

    a_coil_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.item_kind == ITEM_COIL) |-> (r_out.status == ST_OK))
        else $error("coil word carries a status");

    a_stat_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_stat |=> (r_out.last == (r_cnt == '0)))
        else $error("status last flag disagrees with coil count");

endmodule

// ===== sv/modbus_coil_response_checker.sv =====
// Checks a Modbus RTU coil response (read coils, write single coil, write multiple
// coils) one received byte per word. While a frame arrives a byte is taken every
// cycle; after the byte marked frame_end the status word is loaded into the output
// register once the output is free, and on a good read-coils response each coil
// data byte follows by a registered buffer read, then an output load that waits
// while the output stalls. Configure only while idle.
module modbus_coil_response_checker #(
    parameter int MAX_COIL_BYTES = mcrc_pkg::MAX_COIL_BYTES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  mcrc_pkg::t_in_word                  i_in_word,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output mcrc_pkg::t_out_word                 o_out_word,
    input  logic                                i_cfg_we,
    input  logic [mcrc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mcrc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import mcrc_pkg::*;

    t_ctrl_cmd cmd;
    t_dp_stat  stat;

    mcrc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    mcrc_dp #(
        .MAX_COIL_BYTES (MAX_COIL_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    assign o_in_ready = cmd.in_ready;

endmodule
